### hdl/gsfp_pkg.sv
// Shared types and constants for the gas sensor frame parser.
// Depends on nothing; every other file in hdl/ imports it.
package gsfp_pkg;

  // Frame layout
  localparam int unsigned FRAME_LAST  = 8;   // checksum byte position
  localparam int unsigned POS_W       = 4;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FORMAT   = 2'd1;
  localparam logic [1:0] ST_CHECKSUM = 2'd2;

  // Sensor type register codes
  localparam logic [1:0] SENSOR_T0 = 2'd0;  // 14-bit value plus fault bit
  localparam logic [1:0] SENSOR_T1 = 2'd1;  // 16-bit value divided by ten

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_TYPE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE  = 1'd1;

  localparam logic [7:0] START_BYTE_RST = 8'hFF;

  // Divide by ten: q = (x * DIV10_MUL) >> DIV10_SHIFT, exact for 16-bit x
  localparam logic [16:0] DIV10_MUL   = 17'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       start_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  gas_id;
    logic [13:0] concentration;
    logic [15:0] range_span;
    logic        fault;
  } out_item_t;

  // One finished frame, handed from the byte tracker to the result stage
  typedef struct packed {
    logic        start_ok;
    logic        sum_ok;
    logic [7:0]  gas_code;
    logic [15:0] conc_raw;
    logic [15:0] range_raw;
  } frame_rec_t;

endpackage

### hdl/gsfp_frame.sv
// Byte tracker: position counter, running sum and captured frame fields.
// Depends on gsfp_pkg; emits one frame record per checksum byte.
module gsfp_frame import gsfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_accept,
  input  in_item_t   in_item,
  input  logic [7:0] start_byte,
  input  logic       rec_take,
  output logic       rec_valid_r,
  output frame_rec_t rec_r
);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_eff;
  logic [7:0]       sum_r, sum_nxt, sum_add;
  logic             match_r, match_nxt;
  logic [7:0]       gas_r, gas_nxt;
  logic [15:0]      conc_r, conc_nxt;
  logic [15:0]      range_r, range_nxt;
  logic             rec_valid_nxt;
  frame_rec_t       rec_nxt;
  logic             last_byte;

  always_comb begin
    pos_eff = in_item.start_of_frame ? '0 : pos_r;
    if (pos_eff > POS_W'(FRAME_LAST)) begin
      pos_eff = '0;
    end
    sum_add   = sum_r + in_item.rx_byte;
    last_byte = (pos_eff == POS_W'(FRAME_LAST));

    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    match_nxt = match_r;
    gas_nxt   = gas_r;
    conc_nxt  = conc_r;
    range_nxt = range_r;

    if (in_accept) begin
      if (pos_eff == '0) begin
        sum_nxt   = '0;
        match_nxt = (in_item.rx_byte == start_byte);
        pos_nxt   = POS_W'(1);
      end else if (last_byte) begin
        pos_nxt = '0;
      end else begin
        sum_nxt = sum_add;
        pos_nxt = pos_eff + POS_W'(1);
        case (pos_eff)
          POS_W'(1): gas_nxt          = in_item.rx_byte;
          POS_W'(4): conc_nxt[15:8]   = in_item.rx_byte;
          POS_W'(5): conc_nxt[7:0]    = in_item.rx_byte;
          POS_W'(6): range_nxt[15:8]  = in_item.rx_byte;
          POS_W'(7): range_nxt[7:0]   = in_item.rx_byte;
          default: ;
        endcase
      end
    end
  end

  // Capture the frame record on the checksum byte; drop it once taken
  always_comb begin
    rec_nxt           = rec_r;
    rec_valid_nxt     = rec_valid_r && !rec_take;
    if (in_accept && last_byte) begin
      rec_valid_nxt     = 1'b1;
      rec_nxt.start_ok  = match_r;
      rec_nxt.sum_ok    = (sum_add == 8'd0);
      rec_nxt.gas_code  = gas_r;
      rec_nxt.conc_raw  = conc_r;
      rec_nxt.range_raw = range_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      sum_r       <= '0;
      match_r     <= 1'b0;
      rec_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      match_r     <= match_nxt;
      rec_valid_r <= rec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gas_r   <= gas_nxt;
    conc_r  <= conc_nxt;
    range_r <= range_nxt;
    rec_r   <= rec_nxt;
  end

endmodule

### hdl/gsfp_result.sv
// Result stage: judges a frame record and formats the result register.
// Depends on gsfp_pkg; holds the divide-by-ten reciprocal multiply.
module gsfp_result import gsfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rec_valid,
  input  frame_rec_t rec,
  input  logic [1:0] sensor_type,
  output logic       slot_free,
  output logic       rec_take,
  output logic       out_valid_r,
  input  logic       out_ready,
  output out_item_t  out_data_r
);

  logic [32:0] prod;
  out_item_t   res;
  logic        out_valid_nxt;

  assign prod      = rec.conc_raw * DIV10_MUL;
  assign slot_free = !out_valid_r || out_ready;
  assign rec_take  = rec_valid && slot_free;

  always_comb begin
    res = '0;
    if (!rec.start_ok) begin
      res.status = ST_FORMAT;
    end else if (!rec.sum_ok) begin
      res.status = ST_CHECKSUM;
    end else begin
      case (sensor_type)
        SENSOR_T0: begin
          res.status        = ST_OK;
          res.gas_id        = rec.gas_code;
          res.concentration = rec.conc_raw[13:0];
          res.range_span    = rec.range_raw;
          res.fault         = rec.conc_raw[15];
        end
        SENSOR_T1: begin
          res.status        = ST_OK;
          res.gas_id        = rec.gas_code;
          res.concentration = prod[DIV10_SHIFT +: 14];
          res.range_span    = rec.range_raw;
        end
        default: res.status = ST_FORMAT;
      endcase
    end
  end

  assign out_valid_nxt = rec_take ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_take) begin
      out_data_r <= res;
    end
  end

endmodule

### hdl/gas_sensor_frame_parser.sv
// Top level of the gas sensor frame parser: config registers and the two stages.
// Depends on gsfp_pkg, gsfp_frame and gsfp_result.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | request   | in_valid / in_ready  | in_data  (in_item_t)
//   out     | result    | out_valid/ out_ready | out_data (out_item_t)
//   cfg     | write     | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// One byte is taken per cycle while in_ready is high; the frame record lands in the
// cycle after the checksum byte, and the result is registered once the output register is free.
// Rate is set by the one-entry frame record and the output register: a byte
// is refused only while both hold data and out_ready is low.
// Reset (rst_n low at a clock edge) clears position, sum and valid flags,
// sets sensor_type to 0 and start_byte to 0xFF. The cfg port is always ready.
module gas_sensor_frame_parser import gsfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [1:0] sensor_type_r;
  logic [7:0] start_byte_r;
  logic       in_accept;
  logic       rec_valid;
  frame_rec_t rec;
  logic       rec_take;
  logic       slot_free;

  // Configuration: the user writes it only while idle, so no hazard against the stages; the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_type_r <= SENSOR_T0;
      start_byte_r  <= START_BYTE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SENSOR_TYPE: sensor_type_r <= cfg_data[1:0];
        CFG_START_BYTE:  start_byte_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Take a byte whenever the frame record is empty or is moving on this cycle
  assign in_ready  = !rec_valid || slot_free;
  assign in_accept = in_valid && in_ready;

  gsfp_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (in_accept),
    .in_item     (in_data),
    .start_byte  (start_byte_r),
    .rec_take    (rec_take),
    .rec_valid_r (rec_valid),
    .rec_r       (rec)
  );

  gsfp_result u_result (
    .clk         (clk),
    .rst_n       (rst_n),
    .rec_valid   (rec_valid),
    .rec         (rec),
    .sensor_type (sensor_type_r),
    .slot_free   (slot_free),
    .rec_take    (rec_take),
    .out_valid_r (out_valid),
    .out_ready   (out_ready),
    .out_data_r  (out_data)
  );

`ifndef SYNTHESIS
  // Any error status carries all-zero data fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |->
      (out_data.gas_id == 8'd0) && (out_data.concentration == 14'd0) &&
      (out_data.range_span == 16'd0) && !out_data.fault)
    else $error("error result with nonzero fields");

  // Divided value never exceeds 65535 / 10 and carries no fault
  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_OK) && (sensor_type_r == SENSOR_T1) |->
      (out_data.concentration <= 14'd6553) && !out_data.fault)
    else $error("divide-by-ten result out of range");

  // A new result only follows a pending frame record
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(rec_valid))
    else $error("result without a frame record");

  // Bytes are refused only while both stages are occupied
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> rec_valid && out_valid && !out_ready)
    else $error("input stalled with free stage");
`endif

endmodule

### test/tb_gas_sensor_frame_parser.sv
// Testbench for gas_sensor_frame_parser: directed frames, then random frames and noise.
// Each result is checked against a predictor of the frame parser kept in this file.
// Depends on gsfp_pkg (hdl/gsfp_pkg.sv) and the RTL under hdl/.
module tb_gas_sensor_frame_parser;
  import gsfp_pkg::*;

  // Sensor type codes that the block must reject with a format error
  localparam logic [1:0] SENSOR_BAD2 = 2'd2;
  localparam logic [1:0] SENSOR_BAD3 = 2'd3;

  localparam logic [POS_W-1:0] LAST_POS = FRAME_LAST[POS_W-1:0];

  // Handshake idling modes, one per random phase in turn
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 128;
  localparam int DRAIN_CYCLES = 8;       // margin for the block to drain
  localparam int CYCLE_LIMIT  = 200000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  gas_sensor_frame_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // One row of the directed table: a byte, and optionally a hand-written
  // reading to expect and a sensor type to switch to before the byte goes out.
  typedef struct packed {
    logic [7:0] rx;
    logic       sof;
    logic       fixed;
    out_item_t  want;
    logic       retype;
    logic [1:0] new_sel;
  } stim_row_t;

  stim_row_t directed_rows[$];
  out_item_t pending_readings[$];   // readings owed by the block, oldest first
  out_item_t head_reading;

  int mismatch_count = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int send_idle = 0;                // percent of cycles the sender holds off
  int recv_stall = 0;               // percent of cycles the receiver stalls

  // Predictor copy of the configuration registers
  logic [1:0] sensor_sel = SENSOR_T0;
  logic [7:0] start_code = START_BYTE_RST;

  // Predictor copy of the frame state
  logic [POS_W-1:0] frame_pos = '0;
  logic [7:0]       frame_sum = '0;
  logic             start_hit = 1'b0;
  logic [7:0]       gas_hold = '0;
  logic [15:0]      conc_hold = '0;
  logic [15:0]      range_hold = '0;

  // Advance the frame predictor by one accepted byte. On the checksum byte,
  // judge the frame (start byte first, then checksum, then sensor type) and
  // hand back the reading.
  task automatic track_frame_byte(input in_item_t it, output logic done,
                                  output out_item_t res);
    logic [POS_W-1:0] pos;
    logic [7:0]       want_sum;
    logic [15:0]      tenth;
    res  = '0;
    done = 1'b0;
    // A start flag wins over the counter; past the end, fall back to byte 0
    pos = it.start_of_frame ? '0 : frame_pos;
    if (pos > LAST_POS) pos = '0;
    if (pos == '0) begin
      frame_sum = '0;
      start_hit = (it.rx_byte == start_code);
      frame_pos = 4'd1;
    end else if (pos < LAST_POS) begin
      frame_sum = frame_sum + it.rx_byte;
      case (pos)
        4'd1: gas_hold = it.rx_byte;
        4'd4: conc_hold[15:8] = it.rx_byte;
        4'd5: conc_hold[7:0] = it.rx_byte;
        4'd6: range_hold[15:8] = it.rx_byte;
        4'd7: range_hold[7:0] = it.rx_byte;
        default: ;
      endcase
      frame_pos = pos + 4'd1;
    end else begin
      want_sum = ~frame_sum + 8'd1;
      tenth    = conc_hold / 16'd10;
      if (!start_hit) begin
        res.status = ST_FORMAT;
      end else if (want_sum != it.rx_byte) begin
        res.status = ST_CHECKSUM;
      end else if (sensor_sel == SENSOR_T0) begin
        res.status        = ST_OK;
        res.gas_id        = gas_hold;
        res.concentration = conc_hold[13:0];
        res.range_span    = range_hold;
        res.fault         = conc_hold[15];
      end else if (sensor_sel == SENSOR_T1) begin
        res.status        = ST_OK;
        res.gas_id        = gas_hold;
        res.concentration = tenth[13:0];
        res.range_span    = range_hold;
      end else begin
        res.status = ST_FORMAT;   // unknown sensor model
      end
      frame_pos = '0;
      done      = 1'b1;
    end
  endtask

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  task automatic add_row(input logic [7:0] rx, input logic sof, input logic fixed = 1'b0,
                         input out_item_t want = '0, input logic retype = 1'b0,
                         input logic [1:0] new_sel = SENSOR_T0);
    stim_row_t row;
    row.rx      = rx;
    row.sof     = sof;
    row.fixed   = fixed;
    row.want    = want;
    row.retype  = retype;
    row.new_sel = new_sel;
    directed_rows.push_back(row);
  endtask

  // Present one request on the input channel and hold it until accepted.
  // Return right after the accepting edge; the next call or wait_idle takes
  // valid over at the following falling edge.
  task automatic send_byte(input in_item_t it, input logic fixed, input out_item_t want);
    logic      done;
    out_item_t res;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_frame_byte(it, done, res);
    // Typed-in rows override the predictor, which still advances its state
    if (done) pending_readings.push_back(fixed ? want : res);
    items_sent++;
  endtask

  task automatic feed_byte(input logic [7:0] b, input logic sof);
    in_item_t it;
    it.rx_byte        = b;
    it.start_of_frame = sof;
    send_byte(it, 1'b0, '0);
  endtask

  // Drop valid, wait for every owed reading, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_SENSOR_TYPE) sensor_sel = data[1:0];
    else start_code = data;
  endtask

  // Rewrite both registers once the block is idle. Junk in the upper bits of
  // the sensor type write must be ignored.
  task automatic configure(input logic [1:0] sel, input logic [7:0] code);
    logic [7:0] pad;
    pad = rand_byte();
    wait_idle();
    cfg_write(CFG_SENSOR_TYPE, {pad[7:2], sel});
    cfg_write(CFG_START_BYTE, code);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed frames with random content; the rest are cut-off
  // frames and loose noise bytes with a sprinkling of start flags.
  task automatic send_random_frame();
    int          kind;
    int          nbytes;
    int          r;
    logic [7:0]  b;
    logic [7:0]  sum;
    logic        sof0;
    kind = $urandom_range(99);
    if (kind < 80) begin
      b = ($urandom_range(9) == 0) ? rand_byte() : start_code;
      // Skip the flag now and then when the counter is already at byte 0
      sof0 = (frame_pos != '0) || ($urandom_range(3) != 0);
      feed_byte(b, sof0);
      sum = '0;
      for (int i = 1; i < LAST_POS; i++) begin
        r = $urandom_range(7);
        b = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : rand_byte();
        sum = sum + b;
        feed_byte(b, 1'b0);
      end
      b = ($urandom_range(6) == 0) ? rand_byte() : ~sum + 8'd1;
      feed_byte(b, 1'b0);
    end else if (kind < 90) begin
      feed_byte(start_code, 1'b1);
      nbytes = $urandom_range(7, 1);
      repeat (nbytes) feed_byte(rand_byte(), 1'b0);
    end else begin
      nbytes = $urandom_range(12, 1);
      repeat (nbytes) feed_byte(rand_byte(), $urandom_range(7) == 0);
    end
  endtask

  // Receiver: stall at random at the falling edge as the phase asks
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic flag_field(input string what, input logic [15:0] want,
                            input logic [15:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    mismatch_count++;
  endtask

  // Compare each accepted reading with the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: reading with none expected, got %h", $time, out_data);
        mismatch_count++;
      end else begin
        head_reading = pending_readings.pop_front();
        if (out_data.status !== head_reading.status)
          flag_field("status", head_reading.status, out_data.status);
        if (out_data.gas_id !== head_reading.gas_id)
          flag_field("gas_id", head_reading.gas_id, out_data.gas_id);
        if (out_data.concentration !== head_reading.concentration)
          flag_field("concentration", head_reading.concentration, out_data.concentration);
        if (out_data.range_span !== head_reading.range_span)
          flag_field("range_span", head_reading.range_span, out_data.range_span);
        if (out_data.fault !== head_reading.fault)
          flag_field("fault", head_reading.fault, out_data.fault);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  logic [1:0] phase_sel [PHASES] = '{SENSOR_T0, SENSOR_T1, SENSOR_BAD2, SENSOR_T0,
                                     SENSOR_T1, SENSOR_BAD3, SENSOR_T1, SENSOR_T0};

  initial begin
    stim_row_t  row;
    in_item_t   it;
    logic [7:0] code;
    int         phase_start;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Frame at the reset settings with extreme payload: fault bit set,
    // concentration masked to 14 bits, full range at its top.
    add_row(8'hFF, 1'b1); add_row(8'h01, 1'b0); add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0); add_row(8'hFF, 1'b0); add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0); add_row(8'hFF, 1'b0);
    add_row(8'h03, 1'b0, 1'b1, {ST_OK, 8'h01, 14'h3FFF, 16'hFFFF, 1'b1});
    // No start flag at byte 0: the counter alone makes it byte 0. Wrong start
    // byte beats a good checksum, and the error clears every field.
    add_row(8'h00, 1'b0); add_row(8'hFF, 1'b0); add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0); add_row(8'hFF, 1'b0); add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0); add_row(8'hFF, 1'b0);
    add_row(8'h07, 1'b0, 1'b1, {ST_FORMAT, 8'h00, 14'h0000, 16'h0000, 1'b0});
    // Abandon a frame with a start flag mid-frame, then restart it under the
    // divide-by-ten sensor with the largest raw value.
    add_row(8'hFF, 1'b1); add_row(8'h5A, 1'b0);
    add_row(8'hFF, 1'b1, 1'b0, '0, 1'b1, SENSOR_T1);
    add_row(8'h02, 1'b0); add_row(8'h00, 1'b0); add_row(8'h00, 1'b0);
    add_row(8'hFF, 1'b0); add_row(8'hFF, 1'b0); add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b1, {ST_OK, 8'h02, 14'd6553, 16'h0000, 1'b0});

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.retype) configure(row.new_sel, start_code);
      it.rx_byte        = row.rx;
      it.start_of_frame = row.sof;
      send_byte(it, row.fixed, row.want);
    end

    // Random phases: walk the sensor types, the start byte extremes and a
    // random start byte, and rotate through the idling modes.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 3)
        0:       code = 8'h00;
        1:       code = START_BYTE_RST;
        default: code = rand_byte();
      endcase
      configure(phase_sel[p], code);
      case (p % 4)
        IDLE_NONE: begin send_idle = 0;  recv_stall = 0;  end
        IDLE_SEND: begin send_idle = 51; recv_stall = 0;  end
        IDLE_RECV: begin send_idle = 0;  recv_stall = 51; end
        default:   begin send_idle = 27; recv_stall = 27; end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_random_frame();
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### gas_sensor_frame_parser.f
hdl/gsfp_pkg.sv
hdl/gsfp_frame.sv
hdl/gsfp_result.sv
hdl/gas_sensor_frame_parser.sv
test/tb_gas_sensor_frame_parser.sv
